FILE: design/spectrum_band_meter_peak_hold_macros.svh
// assertion macros shared by the spectrum band meter rtl
// expects clk and rst_n in the scope of every use
`ifndef SPECTRUM_BAND_METER_PEAK_HOLD_MACROS_SVH
`define SPECTRUM_BAND_METER_PEAK_HOLD_MACROS_SVH

// same-cycle implication
`define SBM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/sbm_pkg.sv
// shared types, constants, band map and microcode rom of the band meter
// no dependencies
package sbm_pkg;

  localparam int NUM_BANDS  = 8;
  localparam int NUM_BINS   = 256;
  localparam int BAND_W     = $clog2(NUM_BANDS);
  localparam int BIN_W      = $clog2(NUM_BINS);
  localparam int LEVEL_W    = 8;
  localparam int MAG_W      = 32;
  localparam int TIME_W     = 32;
  localparam int DIV_W      = 16;
  localparam int DIV_CNT_W  = $clog2(MAG_W);
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = BAND_W + 2;
  localparam int STEP_W     = 3;

  localparam logic [MAG_W-1:0]   NOISE_FLOOR  = MAG_W'(1500);
  localparam logic [TIME_W-1:0]  DECAY_AGE_MS = TIME_W'(50);
  localparam logic [LEVEL_W-1:0] LEVEL_MAX    = LEVEL_W'(200);
  localparam logic [LEVEL_W-1:0] LEVEL_DECAY  = LEVEL_W'(4);
  localparam logic [LEVEL_W-1:0] PEAK_FALL    = LEVEL_W'(2);

  // upper bin edges of bands 1 to 6, the single bin of band 0 and the unmapped gap bin
  localparam logic [BIN_W-1:0] EDGE_B1 = BIN_W'(5);
  localparam logic [BIN_W-1:0] EDGE_B2 = BIN_W'(7);
  localparam logic [BIN_W-1:0] EDGE_B3 = BIN_W'(15);
  localparam logic [BIN_W-1:0] EDGE_B4 = BIN_W'(30);
  localparam logic [BIN_W-1:0] EDGE_B5 = BIN_W'(53);
  localparam logic [BIN_W-1:0] EDGE_B6 = BIN_W'(200);
  localparam logic [BIN_W-1:0] BIN_B0  = BIN_W'(2);
  localparam logic [BIN_W-1:0] BIN_GAP = BIN_W'(3);

  // microcode step addresses
  localparam logic [STEP_W-1:0] ST_ACCEPT    = STEP_W'(0);
  localparam logic [STEP_W-1:0] ST_KIND      = STEP_W'(1);
  localparam logic [STEP_W-1:0] ST_DIV_GO    = STEP_W'(2);
  localparam logic [STEP_W-1:0] ST_DIV_WAIT  = STEP_W'(3);
  localparam logic [STEP_W-1:0] ST_BAND_SET  = STEP_W'(4);
  localparam logic [STEP_W-1:0] ST_DECAY     = STEP_W'(5);
  localparam logic [STEP_W-1:0] ST_EMIT      = STEP_W'(6);
  localparam logic [STEP_W-1:0] ST_NEXT_BAND = STEP_W'(7);

  typedef enum logic [2:0] {
    JC_NEVER,
    JC_ALWAYS,
    JC_NO_INPUT,
    JC_FRAME,
    JC_IGNORE,
    JC_DIV_BUSY,
    JC_OUT_STALL,
    JC_MORE_BANDS
  } jc_t;

  typedef struct packed {
    logic in_ready;
    logic div_start;
    logic band_set;
    logic decay;
    logic out_valid;
  } ctrl_t;

  typedef struct packed {
    ctrl_t                ctrl;
    jc_t                  jc;
    logic [STEP_W-1:0]    target;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic out_ready;
    logic div_busy;
    logic frame;
    logic ignore;
    logic more_bands;
  } status_t;

  typedef struct packed {
    logic              hit;
    logic [BAND_W-1:0] band;
  } band_sel_t;

  typedef logic [NUM_BANDS-1:0][DIV_W-1:0] div_bank_t;

  function automatic logic [DIV_W-1:0] div_reset(input logic [BAND_W-1:0] b);
    logic [DIV_W-1:0] v;
    case (b)
      BAND_W'(0): v = DIV_W'(500);
      BAND_W'(5): v = DIV_W'(100);
      BAND_W'(6): v = DIV_W'(100);
      BAND_W'(7): v = DIV_W'(50);
      default:    v = DIV_W'(200);
    endcase
    return v;
  endfunction

  function automatic band_sel_t band_of_bin(input logic [BIN_W-1:0] bin);
    band_sel_t s;
    s.hit  = 1'b1;
    s.band = BAND_W'(7);
    if (bin < BIN_B0 || bin == BIN_GAP) begin
      s.hit  = 1'b0;
      s.band = '0;
    end else if (bin == BIN_B0) begin
      s.band = BAND_W'(0);
    end else if (bin <= EDGE_B1) begin
      s.band = BAND_W'(1);
    end else if (bin <= EDGE_B2) begin
      s.band = BAND_W'(2);
    end else if (bin <= EDGE_B3) begin
      s.band = BAND_W'(3);
    end else if (bin <= EDGE_B4) begin
      s.band = BAND_W'(4);
    end else if (bin <= EDGE_B5) begin
      s.band = BAND_W'(5);
    end else if (bin <= EDGE_B6) begin
      s.band = BAND_W'(6);
    end
    return s;
  endfunction

  // control program; the last step falls through to step zero by wrap
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t u;
    u = '{ctrl: '0, jc: JC_NEVER, target: ST_ACCEPT};
    case (step)
      ST_ACCEPT: begin
        u.ctrl.in_ready = 1'b1;
        u.jc            = JC_NO_INPUT;
        u.target        = ST_ACCEPT;
      end
      ST_KIND: begin
        u.jc     = JC_FRAME;
        u.target = ST_DECAY;
      end
      ST_DIV_GO: begin
        u.ctrl.div_start = 1'b1;
        u.jc             = JC_IGNORE;
        u.target         = ST_ACCEPT;
      end
      ST_DIV_WAIT: begin
        u.jc     = JC_DIV_BUSY;
        u.target = ST_DIV_WAIT;
      end
      ST_BAND_SET: begin
        u.ctrl.band_set = 1'b1;
        u.jc            = JC_ALWAYS;
        u.target        = ST_ACCEPT;
      end
      ST_DECAY: begin
        u.ctrl.decay = 1'b1;
      end
      ST_EMIT: begin
        u.ctrl.out_valid = 1'b1;
        u.jc             = JC_OUT_STALL;
        u.target         = ST_EMIT;
      end
      ST_NEXT_BAND: begin
        u.jc     = JC_MORE_BANDS;
        u.target = ST_DECAY;
      end
      default: begin
        u.jc     = JC_ALWAYS;
        u.target = ST_ACCEPT;
      end
    endcase
    return u;
  endfunction

endpackage

FILE: design/sbm_in_if.sv
// input channel of the band meter: bin or frame-end words
// depends on sbm_pkg
interface sbm_in_if import sbm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [BIN_W-1:0]   bin_index;
  logic [MAG_W-1:0]   magnitude;
  logic [TIME_W-1:0]  now_ms;

  modport source (output valid, req_type, bin_index, magnitude, now_ms, input ready);
  modport sink (input valid, req_type, bin_index, magnitude, now_ms, output ready);
endinterface

FILE: design/sbm_out_if.sv
// result channel of the band meter: one word per band report
// depends on sbm_pkg
interface sbm_out_if import sbm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BAND_W-1:0]  band_index;
  logic [LEVEL_W-1:0] band_level;
  logic [LEVEL_W-1:0] band_peak;
  logic               last_band;

  modport source (output valid, band_index, band_level, band_peak, last_band, input ready);
  modport sink (input valid, band_index, band_level, band_peak, last_band, output ready);
endinterface

FILE: design/spectrum_band_meter_peak_hold.sv
// spectrum band meter with peak hold: top level, divisor registers and apb port
// depends on sbm_pkg, sbm_in_if, sbm_out_if, sbm_div, sbm_seq, sbm_dp and the macros
//
// usage
//   in_if  : valid/ready words, req_type 0 = spectrum bin, 1 = frame end
//   out_if : valid/ready words, eight band reports per frame end, band 0 first,
//            last_band marks band 7; a bin word never gives a report
//   apb    : eight 16-bit divisors at byte addresses 0, 4 .. 28, readable
// timing
//   one word at a time; in_if.ready is high only while the sequencer waits
//   a loud binned word waits on the divider, which runs 32 single-bit steps
//   a quiet or unmapped bin is dropped without a divide or a band update
//   a frame end runs the decay, report and next-band steps once for each band
// reset
//   synchronous rst_n clears levels, peaks and stamps and loads default divisors
// stalls
//   each report holds on out_if until taken; the sequencer waits in place and
//   no new word is taken until the last report has gone
`include "spectrum_band_meter_peak_hold_macros.svh"
module spectrum_band_meter_peak_hold import sbm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  sbm_in_if.sink                in_if,
  sbm_out_if.source             out_if,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // divisor register bank
  div_bank_t         div_r, div_nxt;
  logic [BAND_W-1:0] cfg_idx;
  logic              cfg_wr;

  assign cfg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign prdata  = {{(CFG_DATA_W - DIV_W){1'b0}}, div_r[cfg_idx]};

  always_comb begin
    div_nxt = div_r;
    if (cfg_wr) begin
      div_nxt[cfg_idx] = pwdata[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < NUM_BANDS; b++) begin
        div_r[b] <= div_reset(BAND_W'(b));
      end
    end else begin
      div_r <= div_nxt;
    end
  end

  // sequencer and its status inputs
  ctrl_t   ctrl;
  status_t st;
  logic    in_fire, out_fire;
  logic    div_busy, div_start;
  logic    frame, ignore, more_bands;
  logic [MAG_W-1:0] dividend, quotient;
  logic [DIV_W-1:0] divisor;

  assign in_if.ready  = ctrl.in_ready;
  assign out_if.valid = ctrl.out_valid;
  assign in_fire      = in_if.valid && ctrl.in_ready;
  assign out_fire     = out_if.ready && ctrl.out_valid;
  // no divide for a word that is going to be dropped
  assign div_start    = ctrl.div_start && !ignore;

  always_comb begin
    st.in_valid   = in_if.valid;
    st.out_ready  = out_if.ready;
    st.div_busy   = div_busy;
    st.frame      = frame;
    st.ignore     = ignore;
    st.more_bands = more_bands;
  end

  sbm_seq u_seq (
    .clk  (clk),
    .rst_n(rst_n),
    .st   (st),
    .ctrl (ctrl)
  );

  sbm_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(dividend),
    .divisor (divisor),
    .busy    (div_busy),
    .quotient(quotient)
  );

  sbm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .in_fire   (in_fire),
    .out_fire  (out_fire),
    .req_type  (in_if.req_type),
    .bin_index (in_if.bin_index),
    .magnitude (in_if.magnitude),
    .now_ms    (in_if.now_ms),
    .divisors  (div_r),
    .quotient  (quotient),
    .dividend  (dividend),
    .divisor   (divisor),
    .frame     (frame),
    .ignore    (ignore),
    .more_bands(more_bands),
    .band_index(out_if.band_index),
    .band_level(out_if.band_level),
    .band_peak (out_if.band_peak),
    .last_band (out_if.last_band)
  );

  // both reported values within full scale
  logic rpt_in_range;
  assign rpt_in_range = out_if.band_level <= LEVEL_MAX && out_if.band_peak <= LEVEL_MAX;

  `SBM_ASSERT_NOW(a_one_side, out_if.valid, !in_if.ready, "input open while reporting")
  `SBM_ASSERT_NOW(a_level_range, out_if.valid, rpt_in_range, "band value above full scale")
  `SBM_ASSERT_NEXT(a_frame_end, out_fire && out_if.last_band, !out_if.valid, "report after last band")

endmodule

FILE: design/sbm_div.sv
// radix-2 restoring divider, one quotient bit per cycle
// depends on sbm_pkg and the assertion macros
`include "spectrum_band_meter_peak_hold_macros.svh"
module sbm_div import sbm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [MAG_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             busy,
  output logic [MAG_W-1:0] quotient
);

  logic                 busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MAG_W-1:0]     quo_r, quo_nxt;
  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]     dvs_r, dvs_nxt;
  logic [DIV_W:0]       trial, diff;
  logic                 ge;
  logic                 last_bit;

  assign last_bit = cnt_r == DIV_CNT_W'(MAG_W - 1);

  always_comb begin
    trial = {rem_r, quo_r[MAG_W-1]};
    diff  = trial - {1'b0, dvs_r};
    ge    = trial >= {1'b0, dvs_r};

    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_nxt = {quo_r[MAG_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (last_bit) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

  `SBM_ASSERT_NEXT(a_div_start, start, busy_r && cnt_r == '0, "divider did not start")
  `SBM_ASSERT_NEXT(a_div_end, busy_r && !start && last_bit, !busy_r, "divider overran")

endmodule

FILE: design/sbm_seq.sv
// microcode sequencer: step counter, control rom and conditional jumps
// depends on sbm_pkg
module sbm_seq import sbm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  status_t st,
  output ctrl_t   ctrl
);

  logic [STEP_W-1:0] step_r, step_nxt;
  ucode_t            uc;
  logic              take;

  always_comb begin
    uc = ucode_rom(step_r);
    case (uc.jc)
      JC_NEVER:      take = 1'b0;
      JC_ALWAYS:     take = 1'b1;
      JC_NO_INPUT:   take = !st.in_valid;
      JC_FRAME:      take = st.frame;
      JC_IGNORE:     take = st.ignore;
      JC_DIV_BUSY:   take = st.div_busy;
      JC_OUT_STALL:  take = !st.out_ready;
      JC_MORE_BANDS: take = st.more_bands;
      default:       take = 1'b1;
    endcase
    // fall-through from the last step wraps to the accept step
    step_nxt = take ? uc.target : step_r + 1'b1;
    ctrl     = uc.ctrl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_ACCEPT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

FILE: design/sbm_dp.sv
// band datapath: captured word, level/peak/stamp stores, decay and report
// depends on sbm_pkg
module sbm_dp import sbm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  ctrl_t              ctrl,
  input  logic               in_fire,
  input  logic               out_fire,
  input  logic               req_type,
  input  logic [BIN_W-1:0]   bin_index,
  input  logic [MAG_W-1:0]   magnitude,
  input  logic [TIME_W-1:0]  now_ms,
  input  div_bank_t          divisors,
  input  logic [MAG_W-1:0]   quotient,
  output logic [MAG_W-1:0]   dividend,
  output logic [DIV_W-1:0]   divisor,
  output logic               frame,
  output logic               ignore,
  output logic               more_bands,
  output logic [BAND_W-1:0]  band_index,
  output logic [LEVEL_W-1:0] band_level,
  output logic [LEVEL_W-1:0] band_peak,
  output logic               last_band
);

  logic                                frame_r, frame_nxt;
  logic                                ignore_r, ignore_nxt;
  logic [BAND_W-1:0]                   band_r, band_nxt;
  logic [BAND_W-1:0]                   ptr_r, ptr_nxt;
  logic [MAG_W-1:0]                    mag_r, mag_nxt;
  logic [TIME_W-1:0]                   now_r, now_nxt;
  logic [NUM_BANDS-1:0][LEVEL_W-1:0]   level_r, level_nxt;
  logic [NUM_BANDS-1:0][LEVEL_W-1:0]   peak_r, peak_nxt;
  logic [NUM_BANDS-1:0][TIME_W-1:0]    stamp_r, stamp_nxt;

  band_sel_t          sel;
  logic [BAND_W-1:0]  idx;
  logic [LEVEL_W-1:0] cur_level, cur_peak, q_clamp, lv_dec, pk_dec;
  logic [TIME_W-1:0]  age;
  logic               stale;

  always_comb begin
    sel = band_of_bin(bin_index);
    // bins use the band chosen at capture, frames walk the report pointer
    idx       = frame_r ? ptr_r : band_r;
    cur_level = level_r[idx];
    cur_peak  = peak_r[idx];

    q_clamp = (quotient > MAG_W'(LEVEL_MAX)) ? LEVEL_MAX : quotient[LEVEL_W-1:0];
    age     = now_r - stamp_r[idx];
    stale   = age > DECAY_AGE_MS;
    lv_dec  = (cur_level > LEVEL_DECAY) ? cur_level - LEVEL_DECAY : '0;

    frame_nxt  = frame_r;
    ignore_nxt = ignore_r;
    band_nxt   = band_r;
    ptr_nxt    = ptr_r;
    mag_nxt    = mag_r;
    now_nxt    = now_r;
    level_nxt  = level_r;
    peak_nxt   = peak_r;
    stamp_nxt  = stamp_r;
    pk_dec     = cur_peak;

    if (in_fire) begin
      frame_nxt  = req_type;
      ignore_nxt = (magnitude <= NOISE_FLOOR) || !sel.hit;
      band_nxt   = sel.band;
      ptr_nxt    = '0;
      mag_nxt    = magnitude;
      now_nxt    = now_ms;
    end

    if (ctrl.band_set) begin
      level_nxt[idx] = q_clamp;
      if (q_clamp > cur_peak) begin
        peak_nxt[idx] = q_clamp;
      end
      stamp_nxt[idx] = now_r;
    end

    if (ctrl.decay) begin
      if (stale) begin
        level_nxt[idx] = lv_dec;
        stamp_nxt[idx] = now_r;
        if (lv_dec > cur_peak) begin
          pk_dec = lv_dec;
        end
      end
      peak_nxt[idx] = (pk_dec > PEAK_FALL) ? pk_dec - PEAK_FALL : '0;
    end

    if (out_fire) begin
      ptr_nxt = ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r  <= 1'b0;
      ignore_r <= 1'b0;
      ptr_r    <= '0;
      level_r  <= '0;
      peak_r   <= '0;
      stamp_r  <= '0;
    end else begin
      frame_r  <= frame_nxt;
      ignore_r <= ignore_nxt;
      ptr_r    <= ptr_nxt;
      level_r  <= level_nxt;
      peak_r   <= peak_nxt;
      stamp_r  <= stamp_nxt;
    end
    band_r <= band_nxt;
    mag_r  <= mag_nxt;
    now_r  <= now_nxt;
  end

  assign dividend   = mag_r;
  assign divisor    = divisors[band_r];
  assign frame      = frame_r;
  assign ignore     = ignore_r;
  // pointer wraps back to zero after the last band is taken
  assign more_bands = ptr_r != '0;
  assign band_index = ptr_r;
  assign band_level = cur_level;
  assign band_peak  = cur_peak;
  assign last_band  = ptr_r == BAND_W'(NUM_BANDS - 1);

endmodule
